>>> hdl/assert_macros.svh
// Assertion macros for the RTL files; the max filter top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

>>> hdl/mf3_pkg.sv
// Package with the widths, register indexes, result type and per-channel max function of the 3x3 max filter.
package mf3_pkg;

    localparam int MAX_WIDTH_DEFAULT = 2048;

    localparam int PIX_W       = 24;
    localparam int CH_W        = 8;
    localparam int ROW_W       = 12;
    localparam int COL_W       = 11;
    localparam int FW_W        = 12;
    localparam int FH_W        = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_ADDR_W  = 1;
    localparam int OUT_DATA_W  = 48;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd480;
    localparam logic [FH_W-1:0] HEIGHT_LIMIT       = 13'd4096;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam int FIFO_DEPTH = 8;

    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] pix;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } result_t;

    function automatic logic [PIX_W-1:0] chan_max(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] res;
        res = '0;
        for (int k = 0; k < PIX_W / CH_W; k++) begin
            res[k*CH_W +: CH_W] = (a[k*CH_W +: CH_W] > b[k*CH_W +: CH_W]) ?
                                  a[k*CH_W +: CH_W] : b[k*CH_W +: CH_W];
        end
        return res;
    endfunction

endpackage

>>> hdl/mf3_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module mf3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/max_filter_3x3_rgb.sv
// Top level of the per-channel 3x3 max filter over an RGB raster stream.
//
// channel   direction  handshake                 contents
// s_axis    in         tvalid/tready             one pixel request per item
// m_axis    out        tvalid/tready, tlast      zero to two result pixels per request
// cfg       in         cfg_wr_en                 frame_width, frame_height
//
// A pixel is taken every cycle while the result queue has room; its results
// leave the queue one per cycle while m_axis_tready is high, after the compute stage.
// Both line buffers share one RAM word that is read at pixel acceptance and
// written back on the next cycle. Reset restores the frame size and clears the
// counters and the queue; the line RAM keeps its contents.
// s_axis stalls once the eight-entry result queue holds more than six results,
// or more than four while a pixel is still in the compute stage.
`include "assert_macros.svh"

module max_filter_3x3_rgb #(
    parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [mf3_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // pixel_ch0, pixel_ch1, pixel_ch2
    input  logic [mf3_pkg::PIX_W-1:0]       s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_row, out_col, max_ch0, max_ch1, max_ch2, one zero pad bit
    output logic [mf3_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tlast
);

    import mf3_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = (CW + 1 > FW_W) ? CW + 1 : FW_W;
    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int RAM_W = 2 * PIX_W;

    logic [FW_W-1:0]  frame_width_reg;
    logic [FH_W-1:0]  frame_height_reg;
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic [CW-1:0]    col_count_reg, col_count_next;

    logic             s1_valid_reg;
    logic [1:0]       s1_n_reg;
    logic             s1_filt_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [COL_W-1:0] s1_col2_reg;
    logic [CW-1:0]    s1_addr_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [1:0]       s1_n_next;
    logic             s1_filt_next;
    logic [ROW_W-1:0] s1_row_next;
    logic [COL_W-1:0] s1_col_next;

    logic [PIX_W-1:0] cmax0_reg, cmax1_reg;

    result_t          fifo_reg [FIFO_DEPTH];
    logic [PW-1:0]    wptr_reg, rptr_reg;
    logic [PW:0]      count_reg;

    logic             in_accept, out_pop;
    logic [WW-1:0]    w_eff;
    logic [FH_W-1:0]  h_eff;
    logic [CW-1:0]    c;
    logic [ROW_W-1:0] r;
    logic             last_col;

    logic [RAM_W-1:0] ram_rd_data;
    logic [PIX_W-1:0] colmax, winmax;
    result_t          res0, res1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[FH_W-1:0];
                default:          ;
            endcase
        end
    end

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_pop   = m_axis_tvalid && m_axis_tready;

    // Position of the incoming pixel and the results it will cause.
    always_comb
    begin
        w_eff = WW'(frame_width_reg);
        if (w_eff < WW'(3))
        begin
            w_eff = WW'(3);
        end
        else if (w_eff > WW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        h_eff = frame_height_reg;
        if (h_eff < FH_W'(3))
        begin
            h_eff = FH_W'(3);
        end
        else if (h_eff > HEIGHT_LIMIT)
        begin
            h_eff = HEIGHT_LIMIT;
        end
        c = (WW'(col_count_reg) >= w_eff) ? '0 : col_count_reg;
        r = (FH_W'(row_count_reg) >= h_eff) ? '0 : row_count_reg;
        last_col = (WW'(c) == w_eff - WW'(1));

        if (last_col)
        begin
            col_count_next = '0;
            row_count_next = (FH_W'(r) + FH_W'(1) >= h_eff) ? '0 : r + ROW_W'(1);
        end
        else
        begin
            col_count_next = c + CW'(1);
            row_count_next = r;
        end

        s1_filt_next = 1'b0;
        s1_col_next  = COL_W'(c);
        s1_row_next  = r - ROW_W'(1);
        s1_n_next    = 2'd1;
        if (r == '0)
        begin
            s1_row_next = '0;
        end
        else if (r == ROW_W'(1))
        begin
            s1_row_next = ROW_W'(h_eff - FH_W'(1));
        end
        else if (c == '0)
        begin
            s1_col_next = '0;
        end
        else if (c == CW'(1))
        begin
            s1_n_next = 2'd0;
        end
        else
        begin
            s1_filt_next = 1'b1;
            s1_col_next  = COL_W'(c - CW'(1));
            s1_n_next    = last_col ? 2'd2 : 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
            if (in_accept)
            begin
                row_count_reg <= row_count_next;
                col_count_reg <= col_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_n_reg    <= s1_n_next;
            s1_filt_reg <= s1_filt_next;
            s1_row_reg  <= s1_row_next;
            s1_col_reg  <= s1_col_next;
            s1_col2_reg <= COL_W'(c);
            s1_addr_reg <= c;
            s1_pix_reg  <= s_axis_tdata;
        end
        if (s1_valid_reg)
        begin
            cmax1_reg <= cmax0_reg;
            cmax0_reg <= colmax;
        end
    end

    // Word layout: row above in the low half, row two above in the high half.
    mf3_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data ({ram_rd_data[PIX_W-1:0], s1_pix_reg}),
        .rd_en   (in_accept),
        .rd_addr (c),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        colmax = chan_max(chan_max(ram_rd_data[RAM_W-1:PIX_W], ram_rd_data[PIX_W-1:0]),
                          s1_pix_reg);
        winmax = chan_max(chan_max(colmax, cmax0_reg), cmax1_reg);

        res0.row  = s1_row_reg;
        res0.col  = s1_col_reg;
        res0.pix  = s1_filt_reg ? winmax : '0;
        res0.last = (s1_n_reg == 2'd1);
        res1.row  = s1_row_reg;
        res1.col  = s1_col2_reg;
        res1.pix  = '0;
        res1.last = 1'b1;
    end

    // Result queue.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && (s1_n_reg != 2'd0))
        begin
            fifo_reg[wptr_reg] <= res0;
        end
        if (s1_valid_reg && (s1_n_reg == 2'd2))
        begin
            fifo_reg[wptr_reg + PW'(1)] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (s1_valid_reg)
            begin
                wptr_reg <= wptr_reg + PW'(s1_n_reg);
            end
            if (out_pop)
            begin
                rptr_reg <= rptr_reg + PW'(1);
            end
            count_reg <= count_reg + (s1_valid_reg ? (PW+1)'(s1_n_reg) : '0)
                         - (PW+1)'(out_pop);
        end
    end

    assign s_axis_tready = ((PW+2)'(count_reg) + (s1_valid_reg ? (PW+2)'(2) : '0))
                           <= (PW+2)'(FIFO_DEPTH - 2);
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tlast  = fifo_reg[rptr_reg].last;
    assign m_axis_tdata  = {1'b0, fifo_reg[rptr_reg].pix, fifo_reg[rptr_reg].col,
                            fifo_reg[rptr_reg].row};

    `ASSERT_NEVER(a_fifo_overflow, clk, rst_n, count_reg > (PW+1)'(FIFO_DEPTH), "result queue overflow")
    `ASSERT_NEVER(a_ram_collision, clk, rst_n, in_accept && s1_valid_reg && (c == s1_addr_reg), "line RAM read and write hit one entry")
    `ASSERT_CLK(a_stage_follows, clk, rst_n, in_accept |=> s1_valid_reg, "accepted pixel did not reach the compute stage")
    `ASSERT_CLK(a_pop_empties, clk, rst_n, (count_reg == (PW+1)'(1) && out_pop && !s1_valid_reg) |=> !m_axis_tvalid, "queue still valid after last result left")

endmodule
